// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check themselves; the core top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/dsc_pkg.sv =====
// Types, constants and command/status structs for the divisor sum classifier.
`default_nettype none
package dsc_pkg;

  localparam int NUMBER_WIDTH = 32;
  localparam int IN_TDATA_W   = ((NUMBER_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = 8;
  localparam int CNT_W        = $clog2(NUMBER_WIDTH);

  localparam logic [1:0] CLASS_DEFICIENT = 2'd0;
  localparam logic [1:0] CLASS_PERFECT   = 2'd1;
  localparam logic [1:0] CLASS_ABUNDANT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_INIT,
    ST_DIV,
    ST_EVAL,
    ST_ADD_I,
    ST_ADD_Q,
    ST_INC,
    ST_RESULT
  } dsc_state_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_step;
    logic       add_i;
    logic       add_q;
    logic       inc_i;
    logic       pend_load;
    logic       pend_prime;
    logic [1:0] pend_cls;
    logic       out_load;
  } dsc_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic div_last;
    logic q_lt_i;
    logic q_eq_i;
    logic r_zero;
    logic over;
    logic acc_lt_n;
    logic found;
  } dsc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/dsc_datapath.sv =====
// Datapath: operand registers, bit-serial divider, divisor sum and result registers.
`default_nettype none
module dsc_datapath (
  input  wire logic                            clk,
  input  wire logic [dsc_pkg::NUMBER_WIDTH-1:0] number,
  input  wire dsc_pkg::dsc_cmd_t               cmd,
  output dsc_pkg::dsc_stat_t                   stat,
  output logic                                 out_prime,
  output logic [1:0]                           out_cls
);
  import dsc_pkg::*;

  logic [NUMBER_WIDTH-1:0] n_r, n_nxt;
  logic [NUMBER_WIDTH-1:0] i_r, i_nxt;
  logic [NUMBER_WIDTH-1:0] acc_r, acc_nxt;
  logic [NUMBER_WIDTH-1:0] quo_r, quo_nxt;
  logic [NUMBER_WIDTH-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    found_r, found_nxt;
  logic                    pend_prime_r, pend_prime_nxt;
  logic [1:0]              pend_cls_r, pend_cls_nxt;
  logic                    out_prime_r, out_prime_nxt;
  logic [1:0]              out_cls_r, out_cls_nxt;

  logic [NUMBER_WIDTH:0]   rem_shift;
  logic [NUMBER_WIDTH:0]   rem_diff;
  logic                    rem_ge;
  logic [NUMBER_WIDTH-1:0] add_d;
  logic [NUMBER_WIDTH-1:0] headroom;
  logic                    over;

  always_comb begin
    // one restoring-division step per cycle, dividend bits shift out of quo_r
    rem_shift = {rem_r, quo_r[NUMBER_WIDTH-1]};
    rem_diff  = rem_shift - {1'b0, i_r};
    rem_ge    = !rem_diff[NUMBER_WIDTH];
    add_d     = cmd.add_q ? quo_r : i_r;
    headroom  = n_r - acc_r;
    over      = add_d > headroom;
  end

  always_comb begin
    n_nxt          = n_r;
    i_nxt          = i_r;
    acc_nxt        = acc_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    pend_prime_nxt = pend_prime_r;
    pend_cls_nxt   = pend_cls_r;
    out_prime_nxt  = out_prime_r;
    out_cls_nxt    = out_cls_r;
    if (cmd.load) begin
      n_nxt     = number;
      i_nxt     = NUMBER_WIDTH'(2);
      acc_nxt   = NUMBER_WIDTH'(1);
      found_nxt = 1'b0;
    end
    if (cmd.div_start) begin
      quo_nxt = n_r;
      rem_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      quo_nxt = {quo_r[NUMBER_WIDTH-2:0], rem_ge};
      rem_nxt = rem_ge ? rem_diff[NUMBER_WIDTH-1:0] : rem_shift[NUMBER_WIDTH-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.add_i) begin
      found_nxt = 1'b1;
    end
    if ((cmd.add_i || cmd.add_q) && !over) begin
      acc_nxt = acc_r + add_d;
    end
    if (cmd.inc_i) begin
      i_nxt = i_r + NUMBER_WIDTH'(1);
    end
    if (cmd.pend_load) begin
      pend_prime_nxt = cmd.pend_prime;
      pend_cls_nxt   = cmd.pend_cls;
    end
    if (cmd.out_load) begin
      out_prime_nxt = pend_prime_r;
      out_cls_nxt   = pend_cls_r;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    acc_r        <= acc_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    found_r      <= found_nxt;
    pend_prime_r <= pend_prime_nxt;
    pend_cls_r   <= pend_cls_nxt;
    out_prime_r  <= out_prime_nxt;
    out_cls_r    <= out_cls_nxt;
  end

  always_comb begin
    stat.n_zero   = n_r == '0;
    stat.n_one    = n_r == NUMBER_WIDTH'(1);
    stat.div_last = cnt_r == CNT_W'(NUMBER_WIDTH - 1);
    stat.q_lt_i   = quo_r < i_r;
    stat.q_eq_i   = quo_r == i_r;
    stat.r_zero   = rem_r == '0;
    stat.over     = over;
    stat.acc_lt_n = acc_r < n_r;
    stat.found    = found_r;
  end

  assign out_prime = out_prime_r;
  assign out_cls   = out_cls_r;

endmodule
`default_nettype wire

// ===== rtl/dsc_ctrl.sv =====
// Controller: sequences trial division and result hand-off.
`default_nettype none
module dsc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire dsc_pkg::dsc_stat_t stat,
  output dsc_pkg::dsc_cmd_t       cmd
);
  import dsc_pkg::*;

  dsc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = (stat.n_zero || stat.n_one) ? ST_RESULT : ST_DIV_INIT;
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV:      if (stat.div_last) state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (stat.q_lt_i)      state_nxt = ST_RESULT;
        else if (stat.r_zero) state_nxt = ST_ADD_I;
        else                  state_nxt = ST_INC;
      end
      ST_ADD_I: begin
        if (stat.over)        state_nxt = ST_RESULT;
        else if (stat.q_eq_i) state_nxt = ST_INC;
        else                  state_nxt = ST_ADD_Q;
      end
      ST_ADD_Q:    state_nxt = stat.over ? ST_RESULT : ST_INC;
      ST_INC:      state_nxt = ST_DIV_INIT;
      ST_RESULT:   if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        cmd.pend_load  = 1'b1;
        cmd.pend_prime = 1'b0;
        // zero counts as abundant, one as deficient
        cmd.pend_cls   = stat.n_zero ? CLASS_ABUNDANT : CLASS_DEFICIENT;
      end
      ST_DIV_INIT: cmd.div_start = 1'b1;
      ST_DIV:      cmd.div_step  = 1'b1;
      ST_EVAL: begin
        if (stat.q_lt_i) begin
          cmd.pend_load  = 1'b1;
          cmd.pend_prime = !stat.found;
          cmd.pend_cls   = (!stat.found || stat.acc_lt_n) ? CLASS_DEFICIENT : CLASS_PERFECT;
        end
      end
      ST_ADD_I: begin
        cmd.add_i      = 1'b1;
        cmd.pend_load  = stat.over;
        cmd.pend_prime = 1'b0;
        cmd.pend_cls   = CLASS_ABUNDANT;
      end
      ST_ADD_Q: begin
        cmd.add_q      = 1'b1;
        cmd.pend_load  = stat.over;
        cmd.pend_prime = 1'b0;
        cmd.pend_cls   = CLASS_ABUNDANT;
      end
      ST_INC:      cmd.inc_i = 1'b1;
      ST_RESULT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/divisor_sum_classifier_core.sv =====
// Top level of the divisor sum classifier: primality and deficient/perfect/abundant class.
//
//   port group | dir | payload
//   in_*       | in  | tdata[31:0] number
//   out_*      | out | tdata[0] is_prime, tdata[2:1] abundance_class, tdata[7:3] zero
//
// Each candidate divisor d, from 2 while d <= n/d, passes through divider start, the
// bit-serial divider, evaluation and increment; when d divides n, d is added to the sum,
// and n/d is added too when n/d != d. 0 and 1 skip the divider. Reset is synchronous and
// clears only the controller. The output register holds a result under back-pressure
// while the next item is worked on.
`default_nettype none
module divisor_sum_classifier_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [dsc_pkg::IN_TDATA_W-1:0]  in_tdata,   // number
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [dsc_pkg::OUT_TDATA_W-1:0]      out_tdata   // is_prime, abundance_class, zero pad
);
  import dsc_pkg::*;

  `include "assert_macros.svh"

  dsc_cmd_t   cmd;
  dsc_stat_t  stat;
  logic       res_prime;
  logic [1:0] res_cls;

  dsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dsc_datapath u_datapath (
    .clk       (clk),
    .number    (in_tdata[NUMBER_WIDTH-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_prime (res_prime),
    .out_cls   (res_cls)
  );

  assign out_tdata = {(OUT_TDATA_W - 3)'(0), res_cls, res_prime};

  `ASSERT_IMPL(a_prime_is_deficient, clk, rst_n, out_tvalid && out_tdata[0],
               out_tdata[2:1] == CLASS_DEFICIENT)
  `ASSERT_IMPL(a_class_code_valid, clk, rst_n, out_tvalid, out_tdata[2:1] != 2'd3)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_IMPL(a_add_needs_divisor, clk, rst_n, cmd.add_i || cmd.add_q, stat.r_zero)

endmodule
`default_nettype wire
